/* hw/rtl/dns_query_name_extractor_core_macros.svh */
// Assertion macros used by the checker file of the DNS query-name extractor.
`ifndef DNS_QUERY_NAME_EXTRACTOR_CORE_MACROS_SVH
`define DNS_QUERY_NAME_EXTRACTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DQNE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dqne check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DQNE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dqne check failed");

`endif

/* hw/rtl/dqne_pkg.sv */
// ----------------------------------------------------------------------------
// dqne_pkg
// Offsets, codes and helper functions shared by the query-name extractor.
// ----------------------------------------------------------------------------
package dqne_pkg;

	localparam int OFS_PROTO   = 23;
	localparam int OFS_SRC     = 26;
	localparam int OFS_DST     = 30;
	localparam int OFS_SPORT   = 34;
	localparam int OFS_DPORT   = 36;
	localparam int OFS_PAYLOAD = 42;
	localparam int OFS_FLAGS   = 45;
	localparam int OFS_NAME    = 54;

	localparam int RESULT_W = 12;
	localparam int ADDR_W   = 2;
	localparam int DATA_W   = 32;

	localparam logic [ADDR_W-1:0] ADDR_SERVICE_PORT = 2'd0;

	localparam logic [7:0]  RESERVED_MASK = 8'h70;
	localparam logic [15:0] DEFAULT_PORT  = 16'd53;
	localparam logic [7:0]  PROTO_UDP     = 8'd17;
	localparam logic [7:0]  PROTO_TCP     = 8'd6;
	localparam logic [7:0]  DOT_CHAR      = 8'd46;

	// Which header field, if any, a byte belongs to.
	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_PROTO,
		CLS_SRC,
		CLS_DST,
		CLS_SPORT,
		CLS_DPORT,
		CLS_FLAGS,
		CLS_NAME
	} cls_t;

	// Classification handed from the front end to the back end with each byte.
	typedef struct packed {
		cls_t       cls;
		logic [1:0] lane;
		logic       name_head;
		logic       live;
		logic       payload;
		logic       last;
	} front_ctl_t;

	function automatic logic [7:0] to_lower(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'd65 && b <= 8'd90) begin
			r = b + 8'd32;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/dns_query_name_extractor_core.sv */
// ----------------------------------------------------------------------------
// dns_query_name_extractor_core
// DNS query-name extractor for captured Ethernet/IPv4/UDP or TCP frames.
// ----------------------------------------------------------------------------
// Usage: frame bytes enter on the request channel (data_valid/data_ready,
// data_byte, last_byte), starting at the Ethernet header, with last_byte set
// on the final byte. Each request yields exactly one result on the result
// channel (result_valid/result_ready): the byte itself, payload and name
// flags and the lowercase dotted name character. The result of the last
// byte also carries the packet verdict: DNS port match, name validity, the
// name or payload length and the IPv4 addresses.
// An accepted request is written into the queue, moves on into the result
// register once that is free, and is then offered on result_valid. One
// request is taken every cycle while results are drained. When the receiver
// stalls, the block holds up to three requests (one in the result register,
// two in the queue) and then drops data_ready; it rises again the cycle
// after the next result is taken, and nothing is lost or repeated.
// Reset clears the byte offset and all per-packet state and sets
// service_port to 53. The APB port holds the one register, service_port,
// at address 0; it should be written only while the block is idle.
module dns_query_name_extractor_core #(
	parameter int MAX_PACKET = 2048
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// APB configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [dqne_pkg::ADDR_W-1:0]         paddr,
	input  logic [dqne_pkg::DATA_W-1:0]         pwdata,
	output logic [dqne_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	// Request channel
	input  logic                                data_valid,
	output logic                                data_ready,
	input  logic [7:0]                          data_byte,
	input  logic                                last_byte,
	// Result channel
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [7:0]                          raw_byte,
	output logic                                in_payload,
	output logic                                in_name,
	output logic [7:0]                          name_char,
	output logic                                packet_end,
	output logic                                is_dns,
	output logic                                name_ok,
	output logic [dqne_pkg::RESULT_W-1:0]       result_length,
	output logic [31:0]                         source_address,
	output logic [31:0]                         destination_address
);

	// The offset counter must hold MAX_PACKET itself, where it saturates.
	localparam int OFS_W   = $clog2(MAX_PACKET + 1);
	localparam int CTL_W   = $bits(dqne_pkg::front_ctl_t);
	localparam int ENTRY_W = CTL_W + 8 + OFS_W;

	logic [15:0]          service_port_q;
	logic                 cfg_write;

	logic                 push;
	logic                 pop;
	logic                 queue_full;
	logic                 queue_empty;
	logic [OFS_W-1:0]     front_offset;
	dqne_pkg::front_ctl_t front_ctl;
	logic [ENTRY_W-1:0]   wr_entry;
	logic [ENTRY_W-1:0]   rd_entry;
	dqne_pkg::front_ctl_t back_ctl;
	logic [7:0]           back_byte;
	logic [OFS_W-1:0]     back_offset;

	// Configuration register. Writes complete in the APB access phase.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready
		&& (paddr == dqne_pkg::ADDR_SERVICE_PORT);
	assign prdata    = (paddr == dqne_pkg::ADDR_SERVICE_PORT)
		? {{(dqne_pkg::DATA_W-16){1'b0}}, service_port_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			service_port_q <= dqne_pkg::DEFAULT_PORT;
		end else if (cfg_write) begin
			service_port_q <= pwdata[15:0];
		end
	end

	// Front end: offset tracking and field classification.
	dqne_front #(
		.MAX_PACKET(MAX_PACKET),
		.OFS_W     (OFS_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_valid(data_valid),
		.data_ready(data_ready),
		.last_byte (last_byte),
		.queue_full(queue_full),
		.push      (push),
		.offset    (front_offset),
		.ctl       (front_ctl)
	);

	assign wr_entry = {front_ctl, data_byte, front_offset};

	dqne_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(2)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (wr_entry),
		.pop   (pop),
		.rdata (rd_entry),
		.empty (queue_empty),
		.full  (queue_full)
	);

	assign back_ctl    = dqne_pkg::front_ctl_t'(rd_entry[ENTRY_W-1 -: CTL_W]);
	assign back_byte   = rd_entry[OFS_W +: 8];
	assign back_offset = rd_entry[OFS_W-1:0];

	// Back end: field capture, label walk and result register.
	dqne_back #(
		.MAX_PACKET(MAX_PACKET),
		.OFS_W     (OFS_W)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.service_port       (service_port_q),
		.queue_empty        (queue_empty),
		.pop                (pop),
		.entry_byte         (back_byte),
		.entry_offset       (back_offset),
		.entry_ctl          (back_ctl),
		.result_valid       (result_valid),
		.result_ready       (result_ready),
		.raw_byte           (raw_byte),
		.in_payload         (in_payload),
		.in_name            (in_name),
		.name_char          (name_char),
		.packet_end         (packet_end),
		.is_dns             (is_dns),
		.name_ok            (name_ok),
		.result_length      (result_length),
		.source_address     (source_address),
		.destination_address(destination_address)
	);

endmodule

/* hw/rtl/dqne_queue.sv */
// ----------------------------------------------------------------------------
// dqne_queue
// Small register FIFO between the classifying front end and the back end.
// ----------------------------------------------------------------------------
module dqne_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic             full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/dqne_front.sv */
// ----------------------------------------------------------------------------
// dqne_front
// Accepts frame bytes, tracks the byte offset and tags each byte with the
// header field it belongs to.
// ----------------------------------------------------------------------------
module dqne_front #(
	parameter int MAX_PACKET = 2048,
	parameter int OFS_W      = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                data_valid,
	output logic                data_ready,
	input  logic                last_byte,
	input  logic                queue_full,
	output logic                push,
	output logic [OFS_W-1:0]    offset,
	output dqne_pkg::front_ctl_t ctl
);

	logic [OFS_W-1:0] off_q;
	logic [OFS_W-1:0] rel_src;
	logic [OFS_W-1:0] rel_dst;
	logic             live;

	assign data_ready = !queue_full;
	assign push       = data_valid && data_ready;
	assign offset     = off_q;

	// Past the size limit the offset saturates and bytes are only passed on.
	assign live    = (off_q < OFS_W'(MAX_PACKET));
	assign rel_src = off_q - OFS_W'(dqne_pkg::OFS_SRC);
	assign rel_dst = off_q - OFS_W'(dqne_pkg::OFS_DST);

	always_comb begin
		ctl            = '0;
		ctl.live       = live;
		ctl.last       = last_byte;
		ctl.payload    = (off_q >= OFS_W'(dqne_pkg::OFS_PAYLOAD));
		ctl.name_head  = (off_q == OFS_W'(dqne_pkg::OFS_NAME));
		ctl.cls        = dqne_pkg::CLS_NONE;
		ctl.lane       = rel_src[1:0];
		if (off_q == OFS_W'(dqne_pkg::OFS_PROTO)) begin
			ctl.cls = dqne_pkg::CLS_PROTO;
		end else if (off_q >= OFS_W'(dqne_pkg::OFS_SRC)
				&& off_q < OFS_W'(dqne_pkg::OFS_SRC + 4)) begin
			ctl.cls = dqne_pkg::CLS_SRC;
		end else if (off_q >= OFS_W'(dqne_pkg::OFS_DST)
				&& off_q < OFS_W'(dqne_pkg::OFS_DST + 4)) begin
			ctl.cls  = dqne_pkg::CLS_DST;
			ctl.lane = rel_dst[1:0];
		end else if (off_q == OFS_W'(dqne_pkg::OFS_SPORT)
				|| off_q == OFS_W'(dqne_pkg::OFS_SPORT + 1)) begin
			ctl.cls = dqne_pkg::CLS_SPORT;
		end else if (off_q == OFS_W'(dqne_pkg::OFS_DPORT)
				|| off_q == OFS_W'(dqne_pkg::OFS_DPORT + 1)) begin
			ctl.cls = dqne_pkg::CLS_DPORT;
		end else if (off_q == OFS_W'(dqne_pkg::OFS_FLAGS)) begin
			ctl.cls = dqne_pkg::CLS_FLAGS;
		end else if (off_q >= OFS_W'(dqne_pkg::OFS_NAME)) begin
			ctl.cls = dqne_pkg::CLS_NAME;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (push) begin
			if (last_byte) begin
				off_q <= '0;
			end else if (live) begin
				off_q <= off_q + 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/dqne_back.sv */
// ----------------------------------------------------------------------------
// dqne_back
// Captures header fields, walks the DNS name labels and registers one result
// per byte, with the packet verdict on the last byte.
// ----------------------------------------------------------------------------
module dqne_back #(
	parameter int MAX_PACKET = 2048,
	parameter int OFS_W      = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [15:0]                         service_port,
	input  logic                                queue_empty,
	output logic                                pop,
	input  logic [7:0]                          entry_byte,
	input  logic [OFS_W-1:0]                    entry_offset,
	input  dqne_pkg::front_ctl_t                entry_ctl,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [7:0]                          raw_byte,
	output logic                                in_payload,
	output logic                                in_name,
	output logic [7:0]                          name_char,
	output logic                                packet_end,
	output logic                                is_dns,
	output logic                                name_ok,
	output logic [dqne_pkg::RESULT_W-1:0]       result_length,
	output logic [31:0]                         source_address,
	output logic [31:0]                         destination_address
);

	localparam int NLO_W = $clog2(MAX_PACKET + 257);
	localparam int RW    = dqne_pkg::RESULT_W;

	typedef enum logic [1:0] {
		WALKING,
		FOUND,
		STOPPED
	} phase_t;

	phase_t           phase_q,    phase_d;
	logic [NLO_W-1:0] nlo_q,      nlo_d;
	logic             reserved_q, reserved_d;
	logic [7:0]       proto_q,    proto_d;
	logic [15:0]      sport_q,    sport_d;
	logic [15:0]      dport_q,    dport_d;
	logic [31:0]      src_q,      src_d;
	logic [31:0]      dst_q,      dst_d;
	logic [RW-1:0]    nlen_q,     nlen_d;

	logic             in_name_d;
	logic [7:0]       ch_d;
	logic [OFS_W-1:0] count;
	logic [RW-1:0]    len_d;
	logic             dns_d;
	logic             valid_q;

	logic [7:0]       b;
	logic [OFS_W-1:0] off;

	assign b   = entry_byte;
	assign off = entry_offset;

	assign pop          = !queue_empty && (!valid_q || result_ready);
	assign result_valid = valid_q;

	always_comb begin
		phase_d    = phase_q;
		nlo_d      = nlo_q;
		reserved_d = reserved_q;
		proto_d    = proto_q;
		sport_d    = sport_q;
		dport_d    = dport_q;
		src_d      = src_q;
		dst_d      = dst_q;
		nlen_d     = nlen_q;
		in_name_d  = 1'b0;
		ch_d       = '0;
		if (entry_ctl.live) begin
			case (entry_ctl.cls)
				dqne_pkg::CLS_PROTO: proto_d = b;
				dqne_pkg::CLS_SRC:   src_d[8*entry_ctl.lane +: 8] = b;
				dqne_pkg::CLS_DST:   dst_d[8*entry_ctl.lane +: 8] = b;
				dqne_pkg::CLS_SPORT: sport_d = {sport_q[7:0], b};
				dqne_pkg::CLS_DPORT: dport_d = {dport_q[7:0], b};
				dqne_pkg::CLS_FLAGS: reserved_d = |(b & dqne_pkg::RESERVED_MASK);
				dqne_pkg::CLS_NAME: begin
					if (phase_q == WALKING && !reserved_q) begin
						if (NLO_W'(off) == nlo_q) begin
							// Label length byte, or the terminator.
							if (b == 8'd0) begin
								if (entry_ctl.name_head) begin
									phase_d = STOPPED;
								end else begin
									phase_d = FOUND;
									nlen_d  = RW'(off - OFS_W'(dqne_pkg::OFS_NAME));
								end
							end else begin
								nlo_d = NLO_W'(off) + NLO_W'(b) + NLO_W'(1);
								if (!entry_ctl.name_head) begin
									in_name_d = 1'b1;
									ch_d      = dqne_pkg::DOT_CHAR;
								end
							end
						end else begin
							in_name_d = 1'b1;
							ch_d      = dqne_pkg::to_lower(b);
						end
					end
				end
				default: ;
			endcase
		end

		count = entry_ctl.live ? OFS_W'(off + 1'b1) : OFS_W'(MAX_PACKET);
		len_d = '0;
		if (phase_d == FOUND) begin
			len_d = nlen_d;
		end else if (count > OFS_W'(dqne_pkg::OFS_PAYLOAD)) begin
			len_d = RW'(count - OFS_W'(dqne_pkg::OFS_PAYLOAD));
		end
		dns_d = (proto_d == dqne_pkg::PROTO_UDP || proto_d == dqne_pkg::PROTO_TCP)
			&& (sport_d == service_port || dport_d == service_port);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			phase_q    <= WALKING;
			nlo_q      <= NLO_W'(dqne_pkg::OFS_NAME);
			reserved_q <= 1'b0;
			proto_q    <= '0;
			sport_q    <= '0;
			dport_q    <= '0;
			src_q      <= '0;
			dst_q      <= '0;
			nlen_q     <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				if (entry_ctl.last) begin
					phase_q    <= WALKING;
					nlo_q      <= NLO_W'(dqne_pkg::OFS_NAME);
					reserved_q <= 1'b0;
					proto_q    <= '0;
					sport_q    <= '0;
					dport_q    <= '0;
					src_q      <= '0;
					dst_q      <= '0;
					nlen_q     <= '0;
				end else begin
					phase_q    <= phase_d;
					nlo_q      <= nlo_d;
					reserved_q <= reserved_d;
					proto_q    <= proto_d;
					sport_q    <= sport_d;
					dport_q    <= dport_d;
					src_q      <= src_d;
					dst_q      <= dst_d;
					nlen_q     <= nlen_d;
				end
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			raw_byte            <= b;
			in_payload          <= entry_ctl.payload;
			in_name             <= in_name_d;
			name_char           <= ch_d;
			packet_end          <= entry_ctl.last;
			is_dns              <= entry_ctl.last && dns_d;
			name_ok             <= entry_ctl.last && (phase_d == FOUND);
			result_length       <= entry_ctl.last ? len_d : '0;
			source_address      <= entry_ctl.last ? src_d : '0;
			destination_address <= entry_ctl.last ? dst_d : '0;
		end
	end

endmodule

/* hw/rtl/dqne_checker.sv */
// ----------------------------------------------------------------------------
// dqne_checker
// Port-level checks on the result channel of the query-name extractor.
// ----------------------------------------------------------------------------
`include "dns_query_name_extractor_core_macros.svh"

module dqne_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          result_valid,
	input logic                          result_ready,
	input logic                          in_payload,
	input logic                          in_name,
	input logic [7:0]                    name_char,
	input logic                          packet_end,
	input logic                          is_dns,
	input logic                          name_ok,
	input logic [dqne_pkg::RESULT_W-1:0] result_length
);

	// A pending result stays offered until the receiver takes it.
	`DQNE_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && !result_ready, result_valid)

	// Name characters only come from the DNS payload.
	`DQNE_ASSERT_NOW(a_name_in_payload, clk, arst_n, result_valid && in_name, in_payload)

	// Name characters are never uppercase letters.
	`DQNE_ASSERT_NOW(a_name_lower, clk, arst_n, result_valid && in_name,
		!(name_char >= 8'd65 && name_char <= 8'd90))

	// Verdict fields are clear on every result but the last of a packet.
	`DQNE_ASSERT_NOW(a_verdict_quiet, clk, arst_n, result_valid && !packet_end,
		!is_dns && !name_ok && result_length == '0)

endmodule

bind dns_query_name_extractor_core dqne_checker u_dqne_checker (.*);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the DNS query-name extractor core.
// ----------------------------------------------------------------------------
// Frames are built as byte queues and streamed into the request channel by
// a clocked driver. A predictor walks every accepted byte through its own
// copy of the header capture and label walk. It queues the result that
// byte should produce. A clocked monitor pops the oldest entry for each
// accepted result and compares every field. The run moves through several
// service_port settings. Each setting is written over APB only once the
// block has drained, and is read back.
// ----------------------------------------------------------------------------
module testbench;

	localparam int MAX_PKT = 2048;
	localparam int HOLD_CYCLES = 120;
	localparam int RANDOM_BYTES = 40;

	// State of the label walk inside the DNS question name.
	typedef enum logic [1:0] {
		WALK_ON,
		WALK_FOUND,
		WALK_STOPPED
	} name_walk_t;

	// One frame byte waiting to be offered, with the idle cycles before it.
	typedef struct {
		logic [7:0] data;
		logic       last;
		int         gap;
	} frame_byte_t;

	// Everything the block reports for one byte.
	typedef struct {
		logic [7:0]                    raw;
		logic                          payload;
		logic                          name;
		logic [7:0]                    ch;
		logic                          last;
		logic                          dns;
		logic                          ok;
		logic [dqne_pkg::RESULT_W-1:0] len;
		logic [31:0]                   src;
		logic [31:0]                   dst;
	} byte_report_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [dqne_pkg::ADDR_W-1:0]   paddr = '0;
	logic [dqne_pkg::DATA_W-1:0]   pwdata = '0;
	logic [dqne_pkg::DATA_W-1:0]   prdata;
	logic                          pready;
	logic                          data_valid = 1'b0;
	logic                          data_ready;
	logic [7:0]                    data_byte = 8'h00;
	logic                          last_byte = 1'b0;
	logic                          result_valid;
	logic                          result_ready = 1'b0;
	logic [7:0]                    raw_byte;
	logic                          in_payload;
	logic                          in_name;
	logic [7:0]                    name_char;
	logic                          packet_end;
	logic                          is_dns;
	logic                          name_ok;
	logic [dqne_pkg::RESULT_W-1:0] result_length;
	logic [31:0]                   source_address;
	logic [31:0]                   destination_address;

	dns_query_name_extractor_core #(
		.MAX_PACKET(MAX_PKT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.data_valid(data_valid),
		.data_ready(data_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.raw_byte(raw_byte),
		.in_payload(in_payload),
		.in_name(in_name),
		.name_char(name_char),
		.packet_end(packet_end),
		.is_dns(is_dns),
		.name_ok(name_ok),
		.result_length(result_length),
		.source_address(source_address),
		.destination_address(destination_address)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor copy of the register and the per-frame state.
	logic [15:0] cfg_service_port = dqne_pkg::DEFAULT_PORT;
	int          frame_pos;
	int          next_label_at;
	name_walk_t  walk;
	logic        flags_reserved;
	logic [7:0]  proto_seen;
	logic [15:0] sport_seen;
	logic [15:0] dport_seen;
	logic [31:0] src_seen;
	logic [31:0] dst_seen;
	int          name_len;

	// Request stream, expected reports and bookkeeping.
	logic [7:0]   frame_bytes[$];
	frame_byte_t  pending_bytes[$];
	byte_report_t expected_reports[$];
	byte_report_t oldest;
	frame_byte_t  tx_item;
	logic         tx_busy = 1'b0;
	int           tx_gap = 0;
	int           tx_max_gap = 0;
	int           rx_max_wait = 0;
	int           rx_wait = 0;
	logic         long_hold = 1'b0;
	logic         req_accepted = 1'b0;
	logic         result_taken = 1'b0;
	int           requests_queued = 0;
	int           requests_taken = 0;
	int           results_seen = 0;
	int           frames_done = 0;
	int           names_found = 0;
	int           dns_frames = 0;
	int           mismatch_count = 0;
	event         hold_results;

	function automatic void clear_frame_state();
		frame_pos = 0;
		next_label_at = dqne_pkg::OFS_NAME;
		walk = WALK_ON;
		flags_reserved = 1'b0;
		proto_seen = '0;
		sport_seen = '0;
		dport_seen = '0;
		src_seen = '0;
		dst_seen = '0;
		name_len = 0;
	endfunction

	// Appends one byte to the frame under construction.
	function automatic void add_byte(input logic [7:0] v);
		frame_bytes.insert(frame_bytes.size(), v);
	endfunction

	// Works out what the block must report for one accepted byte and moves
	// the frame state on. Past MAX_PKT the byte is only passed through.
	function automatic byte_report_t predict_name_byte(input logic [7:0] b, input logic last);
		byte_report_t r;
		int off;
		int frame_len;
		logic live;
		off = frame_pos;
		live = off < MAX_PKT;
		r.name = 1'b0;
		r.ch = 8'h00;
		if (live) begin
			if (off == dqne_pkg::OFS_PROTO)
				proto_seen = b;
			if (off >= dqne_pkg::OFS_SRC && off < dqne_pkg::OFS_SRC + 4)
				src_seen[8 * (off - dqne_pkg::OFS_SRC) +: 8] = b;
			if (off >= dqne_pkg::OFS_DST && off < dqne_pkg::OFS_DST + 4)
				dst_seen[8 * (off - dqne_pkg::OFS_DST) +: 8] = b;
			if (off == dqne_pkg::OFS_SPORT || off == dqne_pkg::OFS_SPORT + 1)
				sport_seen = {sport_seen[7:0], b};
			if (off == dqne_pkg::OFS_DPORT || off == dqne_pkg::OFS_DPORT + 1)
				dport_seen = {dport_seen[7:0], b};
			if (off == dqne_pkg::OFS_FLAGS)
				flags_reserved = (b & dqne_pkg::RESERVED_MASK) != 8'h00;
			// The walk only runs while the reserved flag bits are clear.
			if (off >= dqne_pkg::OFS_NAME && walk == WALK_ON && !flags_reserved) begin
				if (off == next_label_at) begin
					if (b == 8'h00) begin
						if (off == dqne_pkg::OFS_NAME) begin
							walk = WALK_STOPPED;
						end else begin
							walk = WALK_FOUND;
							name_len = off - dqne_pkg::OFS_NAME;
						end
					end else begin
						next_label_at = off + int'(b) + 1;
						// The first length byte gives no dot.
						if (off != dqne_pkg::OFS_NAME) begin
							r.name = 1'b1;
							r.ch = dqne_pkg::DOT_CHAR;
						end
					end
				end else if (off > dqne_pkg::OFS_NAME) begin
					r.name = 1'b1;
					r.ch = (b >= 8'd65 && b <= 8'd90) ? b + 8'd32 : b;
				end
			end
			frame_pos = off + 1;
		end
		r.raw = b;
		r.payload = off >= dqne_pkg::OFS_PAYLOAD;
		r.last = last;
		r.dns = 1'b0;
		r.ok = 1'b0;
		r.len = '0;
		r.src = '0;
		r.dst = '0;
		if (last) begin
			frame_len = live ? off + 1 : MAX_PKT;
			r.dns = (proto_seen == dqne_pkg::PROTO_UDP || proto_seen == dqne_pkg::PROTO_TCP)
				&& (sport_seen == cfg_service_port || dport_seen == cfg_service_port);
			r.ok = walk == WALK_FOUND;
			if (r.ok)
				r.len = dqne_pkg::RESULT_W'(name_len);
			else if (frame_len > dqne_pkg::OFS_PAYLOAD)
				r.len = dqne_pkg::RESULT_W'(frame_len - dqne_pkg::OFS_PAYLOAD);
			else
				r.len = '0;
			r.src = src_seen;
			r.dst = dst_seen;
			clear_frame_state();
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, %0h expected (result %0d)",
				what, got, want, results_seen));
	endtask

	// Result side and request acceptance, both sampled at the rising edge.
	// The result check comes first: a request taken at this edge cannot have
	// its result on the same edge.
	always @(posedge clk) begin
		req_accepted = data_valid && data_ready;
		result_taken = (result_valid === 1'b1) && result_ready;
		if (result_taken) begin
			results_seen++;
			if (expected_reports.size() == 0) begin
				report_mismatch("result arrived with no request outstanding");
			end else begin
				oldest = expected_reports.pop_front();
				check_field("raw_byte", 32'(raw_byte), 32'(oldest.raw));
				check_field("in_payload", 32'(in_payload), 32'(oldest.payload));
				check_field("in_name", 32'(in_name), 32'(oldest.name));
				check_field("name_char", 32'(name_char), 32'(oldest.ch));
				check_field("packet_end", 32'(packet_end), 32'(oldest.last));
				check_field("is_dns", 32'(is_dns), 32'(oldest.dns));
				check_field("name_ok", 32'(name_ok), 32'(oldest.ok));
				check_field("result_length", 32'(result_length), 32'(oldest.len));
				check_field("source_address", source_address, oldest.src);
				check_field("destination_address", destination_address, oldest.dst);
				if (oldest.last) begin
					frames_done++;
					if (oldest.ok)
						names_found++;
					if (oldest.dns)
						dns_frames++;
				end
			end
		end
		if (req_accepted) begin
			expected_reports.insert(expected_reports.size(),
				predict_name_byte(data_byte, last_byte));
			requests_taken++;
		end
	end

	// Request driver. Each byte waits out its own gap, and then valid stays
	// high with a steady payload until the byte is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (data_valid && req_accepted)
				tx_busy = 1'b0;
			if (!tx_busy && pending_bytes.size() != 0) begin
				tx_item = pending_bytes.pop_front();
				tx_gap = tx_item.gap;
				tx_busy = 1'b1;
			end
			if (tx_busy && tx_gap == 0) begin
				data_valid <= 1'b1;
				data_byte <= tx_item.data;
				last_byte <= tx_item.last;
			end else begin
				if (tx_gap > 0)
					tx_gap--;
				data_valid <= 1'b0;
			end
		end
	end

	// Result receiver: a fresh random stall, possibly none, after every result it
	// takes, plus the long hold-off while long_hold is up.
	always @(negedge clk) begin
		if (arst_n) begin
			if (result_taken)
				rx_wait = $urandom_range(0, rx_max_wait);
			if (long_hold) begin
				result_ready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Long hold-off on the result side. It is counted here, at the rising
	// edge, so the receiver sees a settled flag at the falling edge.
	always begin
		@(hold_results);
		@(posedge clk);
		long_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold = 1'b0;
	end

	task automatic read_service_port(input logic [15:0] want);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= dqne_pkg::ADDR_SERVICE_PORT;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[15:0] !== want)
			report_mismatch($sformatf("service_port reads %0h, %0h expected",
				prdata[15:0], want));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Only the low 16 bits of the word land in the register; the rest are
	// random so that the upper data bits toggle too.
	task automatic write_service_port(input logic [15:0] port);
		logic [31:0] word;
		word = $urandom;
		word[15:0] = port;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= dqne_pkg::ADDR_SERVICE_PORT;
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_service_port = port;
		read_service_port(port);
	endtask

	// Waits until every queued byte has been taken and reported.
	task automatic wait_drained();
		while (requests_taken != requests_queued || expected_reports.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Queues the built frame, cut to its first cut bytes when cut is set.
	task automatic ship_frame(input int cut);
		int n;
		frame_byte_t item;
		n = (cut > 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
		for (int i = 0; i < n; i++) begin
			item.data = frame_bytes[i];
			item.last = i == n - 1;
			item.gap = $urandom_range(0, tx_max_gap);
			pending_bytes.insert(pending_bytes.size(), item);
			requests_queued++;
		end
	endtask

	// Fills offsets 0 to 53 with random bytes and sets the fields that matter.
	task automatic build_header(input logic [7:0] proto, input logic [15:0] sp,
			input logic [15:0] dp, input logic [7:0] flags);
		frame_bytes.delete();
		for (int i = 0; i < dqne_pkg::OFS_NAME; i++)
			add_byte(8'($urandom));
		frame_bytes[dqne_pkg::OFS_PROTO] = proto;
		frame_bytes[dqne_pkg::OFS_SPORT] = sp[15:8];
		frame_bytes[dqne_pkg::OFS_SPORT + 1] = sp[7:0];
		frame_bytes[dqne_pkg::OFS_DPORT] = dp[15:8];
		frame_bytes[dqne_pkg::OFS_DPORT + 1] = dp[7:0];
		frame_bytes[dqne_pkg::OFS_FLAGS] = flags;
	endtask

	// Label text leans toward letters of both cases but can hold any byte.
	task automatic add_random_label(input int len);
		logic [7:0] c;
		add_byte(8'(len));
		repeat (len) begin
			case ($urandom_range(0, 3))
				0: c = 8'($urandom_range(65, 90));
				1: c = 8'($urandom_range(97, 122));
				2: c = 8'($urandom_range(45, 57));
				default: c = 8'($urandom);
			endcase
			add_byte(c);
		end
	endtask

	task automatic add_bytes(input int count);
		repeat (count) add_byte(8'($urandom));
	endtask

	task automatic directed_frames();
		// Frame of one byte, and one that ends after the ports, before the payload.
		frame_bytes.delete();
		add_byte(8'hFF);
		ship_frame(0);
		build_header(dqne_pkg::PROTO_UDP, 16'd1234, dqne_pkg::DEFAULT_PORT, 8'h01);
		ship_frame(40);
		// Exactly one payload byte.
		build_header(dqne_pkg::PROTO_TCP, dqne_pkg::DEFAULT_PORT, 16'd9, 8'h00);
		ship_frame(43);
		// Letters at the edges of both letter ranges, the characters just outside
		// the uppercase range, and digits and a hyphen.
		build_header(dqne_pkg::PROTO_UDP, dqne_pkg::DEFAULT_PORT, 16'd5353, 8'h81);
		add_byte(8'd4);
		add_byte("A");
		add_byte("z");
		add_byte("@");
		add_byte("[");
		add_byte(8'd1);
		add_byte("Z");
		add_byte(8'd3);
		add_byte("0");
		add_byte("9");
		add_byte("-");
		add_byte(8'h00);
		add_bytes(4);
		ship_frame(0);
		// Empty name: the terminator sits right at the name start.
		build_header(dqne_pkg::PROTO_TCP, 16'd80, dqne_pkg::DEFAULT_PORT, 8'h00);
		add_byte(8'h00);
		add_bytes(4);
		ship_frame(0);
		// Reserved flag bits set: no walk, even over a good name.
		build_header(dqne_pkg::PROTO_UDP, dqne_pkg::DEFAULT_PORT,
			dqne_pkg::DEFAULT_PORT, 8'h70);
		add_random_label(6);
		add_byte(8'h00);
		ship_frame(0);
		// Right ports, wrong protocol; then right protocol, no port match.
		build_header(8'd1, dqne_pkg::DEFAULT_PORT, dqne_pkg::DEFAULT_PORT, 8'h00);
		add_random_label(2);
		add_byte(8'h00);
		ship_frame(0);
		build_header(dqne_pkg::PROTO_UDP, 16'hFFFF, 16'h0000, 8'h8F);
		add_random_label(2);
		add_byte(8'h00);
		ship_frame(0);
		// Frame ends inside the name, and a label runs past the end.
		build_header(dqne_pkg::PROTO_UDP, dqne_pkg::DEFAULT_PORT, 16'd7, 8'h00);
		add_random_label(8);
		add_byte(8'h00);
		ship_frame(dqne_pkg::OFS_NAME + 5);
		build_header(dqne_pkg::PROTO_UDP, dqne_pkg::DEFAULT_PORT, 16'd7, 8'h00);
		add_random_label(3);
		add_byte(8'd40);
		add_bytes(10);
		ship_frame(0);
	endtask

	// Mostly well-formed DNS frames with random names, then cut frames,
	// empty names and plain noise.
	task automatic random_frame();
		int kind;
		int cut;
		logic [7:0] proto;
		logic [7:0] flags;
		logic [15:0] sp;
		logic [15:0] dp;
		kind = $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: proto = dqne_pkg::PROTO_UDP;
			4, 5, 6: proto = dqne_pkg::PROTO_TCP;
			default: proto = 8'($urandom);
		endcase
		sp = 16'($urandom);
		dp = 16'($urandom);
		case ($urandom_range(0, 3))
			0: sp = cfg_service_port;
			1: dp = cfg_service_port;
			2: begin
				sp = cfg_service_port;
				dp = cfg_service_port;
			end
			default: ;
		endcase
		flags = 8'($urandom);
		if ($urandom_range(0, 7) != 0)
			flags = flags & ~dqne_pkg::RESERVED_MASK;
		if (kind >= 88) begin
			frame_bytes.delete();
			add_bytes($urandom_range(1, 80));
			ship_frame(0);
		end else begin
			build_header(proto, sp, dp, flags);
			if (kind < 80) begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 19) == 0)
						add_random_label($urandom_range(13, 255));
					else
						add_random_label($urandom_range(1, 12));
				end
			end
			add_byte(8'h00);
			add_bytes($urandom_range(0, 6));
			cut = 0;
			if (kind >= 60 && kind < 80)
				cut = $urandom_range(1, frame_bytes.size() - 1);
			ship_frame(cut);
		end
	endtask

	task automatic random_frames(input int budget);
		int start;
		start = requests_queued;
		while (requests_queued - start < budget)
			random_frame();
	endtask

	initial begin
		clear_frame_state();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Reset value of the port, then the directed frames under it.
		read_service_port(dqne_pkg::DEFAULT_PORT);
		tx_max_gap = 4;
		rx_max_wait = 4;
		directed_frames();
		wait_drained();

		// Highest port with no idling on either side.
		tx_max_gap = 0;
		rx_max_wait = 0;
		write_service_port(16'hFFFF);
		random_frames(RANDOM_BYTES);
		wait_drained();

		// Port zero. The receiver holds off while the sender streams, so the
		// internal queue fills and the request side has to stall.
		write_service_port(16'h0000);
		-> hold_results;
		random_frames(RANDOM_BYTES);
		wait_drained();

		// Random port with idling on both sides.
		tx_max_gap = 4;
		rx_max_wait = 4;
		write_service_port(16'($urandom));
		random_frames(RANDOM_BYTES);
		wait_drained();

		// Back to the usual DNS port with uneven idling.
		tx_max_gap = 2;
		rx_max_wait = 3;
		write_service_port(dqne_pkg::DEFAULT_PORT);
		random_frames(RANDOM_BYTES);
		wait_drained();

		repeat (8) @(posedge clk);
		if (expected_reports.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_reports.size()));
		$display("Streamed %0d frames as %0d bytes; %0d of them ended in a complete name.",
			frames_done, results_seen, names_found);
		$display("%0d frames hit the service port across five port values and one long stall.",
			dns_frames);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("CHECK FAILED");
		end
		$finish;
	end

	// The slowest correct run needs well under a tenth of this.
	initial begin
		#2_000_000;
		$display("timeout with %0d results still expected", expected_reports.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/dqne_pkg.sv
hw/rtl/dqne_queue.sv
hw/rtl/dqne_front.sv
hw/rtl/dqne_back.sv
hw/rtl/dns_query_name_extractor_core.sv
hw/rtl/dqne_checker.sv
tb/testbench.sv
